/* hw/rtl/nnss_pkg.sv */
package nnss_pkg;

   // Field widths
   localparam int COORD_W = 8;
   localparam int COLOR_W = 8;
   localparam int ORG_W   = 9;
   localparam int TEXEL_W = 3 * COLOR_W;

   // Defaults for the top level parameters
   localparam int SRC_SIZE_DEF      = 40;
   localparam int SCREEN_WIDTH_DEF  = 64;
   localparam int SCREEN_HEIGHT_DEF = 32;

   // Command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = ORG_W;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y  = 2'd2;

   localparam logic [COORD_W-1:0] DEST_SIZE_RST = 8'd40;

endpackage

/* hw/rtl/nnss_ram.sv */
module nnss_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1600
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port: write and registered read at one address
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/nnss_div.sv */
module nnss_div
   import nnss_pkg::*;
#(
   parameter int QW = 6
) (
   input  logic                  clock,
   input  logic [COORD_W+QW-1:0] dividend,
   input  logic [COORD_W-1:0]    divisor,
   output logic [QW-1:0]         quotient
);

   localparam int PW = COORD_W + QW;

   // Stage taps: remainder and divisor into each stage, quotient out of each
   logic [PW-1:0]      rem_s [QW];
   logic [COORD_W-1:0] dsr_s [QW];
   logic [QW-1:0]      quo_s [QW+1];

   assign rem_s[0] = dividend;
   assign dsr_s[0] = divisor;
   assign quo_s[0] = '0;

   // One quotient bit per stage, most significant first
   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int B = QW - 1 - k;
      logic [PW-1:0] sub_w;
      logic          fit_w;
      logic [QW-1:0] quo_in;
      logic [QW-1:0] quo_ff;

      assign sub_w = PW'(dsr_s[k]) << B;
      assign fit_w = rem_s[k] >= sub_w;

      always_comb begin
         quo_in    = quo_s[k];
         quo_in[B] = fit_w;
      end

      always_ff @(posedge clock) begin
         quo_ff <= quo_in;
      end

      assign quo_s[k+1] = quo_ff;

      // Carry the partial remainder and divisor to the next stage
      if (k < QW - 1) begin : g_carry
         logic [PW-1:0]      rem_in;
         logic [PW-1:0]      rem_ff;
         logic [COORD_W-1:0] dsr_ff;

         assign rem_in = fit_w ? rem_s[k] - sub_w : rem_s[k];

         always_ff @(posedge clock) begin
            rem_ff <= rem_in;
            dsr_ff <= dsr_s[k];
         end

         assign rem_s[k+1] = rem_ff;
         assign dsr_s[k+1] = dsr_ff;
      end
   end

   assign quotient = quo_s[QW];

endmodule

/* hw/rtl/nearest_neighbor_sprite_scaler.sv */
// Nearest-neighbor sprite scaler.
// Input channel: a beat is taken on every clock edge with start high (busy
// stays low, the block takes one beat per cycle). req_cmd selects a texel
// load into the source store or a sample of one destination pixel.
// Configuration: csr_we writes csr_wdata into the register at csr_index
// (destination size, screen origin x, screen origin y); write only while no
// beats are in flight.
// Result channel: every input beat gives exactly one result beat, marked by
// rsp_strobe for one cycle, in input order. Samples that land on screen
// carry rsp_visible, the screen coordinate and the texel color; loads and
// clipped samples return all fields zero.
// Pipeline: the entry register, then the divider that produces one
// source-coordinate bit per stage, then the texel store read and the
// output register.
// Throughput: one beat per cycle, loads and samples mixed freely.
// Reset clears all valid bits and sets the registers to their defaults; the
// texel store is not cleared, so a sample must only hit texels already
// loaded. The receiver has no stall: rsp_strobe is presented once and the
// beat must be taken in that cycle.
module nearest_neighbor_sprite_scaler
   import nnss_pkg::*;
#(
   parameter int SRC_SIZE      = SRC_SIZE_DEF,
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input channel
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic [COORD_W-1:0]    req_col,
   input  logic [COORD_W-1:0]    req_row,
   input  logic [COLOR_W-1:0]    req_red_in,
   input  logic [COLOR_W-1:0]    req_green_in,
   input  logic [COLOR_W-1:0]    req_blue_in,
   // Result channel
   output logic                  rsp_strobe,
   output logic                  rsp_visible,
   output logic [COORD_W-1:0]    rsp_screen_x,
   output logic [COORD_W-1:0]    rsp_screen_y,
   output logic [COLOR_W-1:0]    rsp_red_out,
   output logic [COLOR_W-1:0]    rsp_green_out,
   output logic [COLOR_W-1:0]    rsp_blue_out,
   // Configuration port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int QW    = $clog2(SRC_SIZE);
   localparam int PW    = COORD_W + QW;
   localparam int DEPTH = SRC_SIZE * SRC_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = COORD_W + 2;

   typedef struct packed {
      logic               load_we;
      logic               vis;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic [AW-1:0]      addr;
      logic [TEXEL_W-1:0] wdata;
   } meta_type;

   // Configuration registers
   logic [COORD_W-1:0] dest_size_ff;
   logic [ORG_W-1:0]   origin_x_ff;
   logic [ORG_W-1:0]   origin_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_size_ff <= DEST_SIZE_RST;
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEST_SIZE: dest_size_ff <= csr_wdata[COORD_W-1:0];
            CSR_ORIGIN_X:  origin_x_ff  <= csr_wdata;
            CSR_ORIGIN_Y:  origin_y_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Entry stage: bounds, screen position, scaled products, load address
   logic signed [SW-1:0] px_w;
   logic signed [SW-1:0] py_w;
   logic                 in_dest_w;
   logic                 on_screen_w;
   logic                 in_src_w;
   logic [PW-1:0]        prod_x_w;
   logic [PW-1:0]        prod_y_w;
   meta_type             meta_in;

   assign px_w = $signed({origin_x_ff[ORG_W-1], origin_x_ff}) + $signed({2'b00, req_col});
   assign py_w = $signed({origin_y_ff[ORG_W-1], origin_y_ff}) + $signed({2'b00, req_row});

   assign in_dest_w   = (req_col < dest_size_ff) && (req_row < dest_size_ff);
   assign on_screen_w = !px_w[SW-1] && (px_w < $signed(SW'(SCREEN_WIDTH))) &&
                        !py_w[SW-1] && (py_w < $signed(SW'(SCREEN_HEIGHT)));
   assign in_src_w    = (req_col < COORD_W'(SRC_SIZE)) && (req_row < COORD_W'(SRC_SIZE));

   // Zero dividends outside the destination keep the quotient below SRC_SIZE for a nonzero size
   assign prod_x_w = in_dest_w ? PW'(req_col) * PW'(SRC_SIZE) : '0;
   assign prod_y_w = in_dest_w ? PW'(req_row) * PW'(SRC_SIZE) : '0;

   always_comb begin
      meta_in.load_we = (req_cmd == CMD_LOAD) && in_src_w;
      meta_in.vis     = (req_cmd == CMD_SAMPLE) && in_dest_w && on_screen_w;
      meta_in.px      = px_w[COORD_W-1:0];
      meta_in.py      = py_w[COORD_W-1:0];
      meta_in.addr    = AW'(req_row) * AW'(SRC_SIZE) + AW'(req_col);
      meta_in.wdata   = {req_red_in, req_green_in, req_blue_in};
   end

   logic [PW-1:0]      prod_x_ff;
   logic [PW-1:0]      prod_y_ff;
   logic [COORD_W-1:0] dsr_ff;
   logic               vld_ff [QW+1];
   meta_type           meta_ff [QW+1];

   always_ff @(posedge clock) begin
      prod_x_ff  <= prod_x_w;
      prod_y_ff  <= prod_y_w;
      dsr_ff     <= dest_size_ff;
      meta_ff[0] <= meta_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= start && !busy;
      end
   end

   // Advance the side information alongside the divider stages
   for (genvar k = 0; k < QW; k++) begin : g_meta
      always_ff @(posedge clock) begin
         meta_ff[k+1] <= meta_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
   end

   // Map destination back to source, one quotient bit per stage
   logic [QW-1:0] src_x_w;
   logic [QW-1:0] src_y_w;

   nnss_div #(.QW(QW)) u_div_x (
      .clock    (clock),
      .dividend (prod_x_ff),
      .divisor  (dsr_ff),
      .quotient (src_x_w)
   );

   nnss_div #(.QW(QW)) u_div_y (
      .clock    (clock),
      .dividend (prod_y_ff),
      .divisor  (dsr_ff),
      .quotient (src_y_w)
   );

   // Texel store access: loads write, samples read, both in item order
   logic                 ram_we;
   logic [AW-1:0]        ram_addr;
   logic [TEXEL_W-1:0]   ram_rdata;
   meta_type             tail_w;

   assign tail_w   = meta_ff[QW];
   assign ram_we   = vld_ff[QW] && tail_w.load_we;
   assign ram_addr = tail_w.load_we ? tail_w.addr
                                    : AW'(src_y_w) * AW'(SRC_SIZE) + AW'(src_x_w);

   nnss_ram #(.WIDTH(TEXEL_W), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (tail_w.wdata),
      .rdata (ram_rdata)
   );

   // Hold position info while the read completes
   logic               rd_vld_ff;
   logic               rd_vis_ff;
   logic [COORD_W-1:0] rd_px_ff;
   logic [COORD_W-1:0] rd_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      rd_vis_ff <= tail_w.vis;
      rd_px_ff  <= tail_w.px;
      rd_py_ff  <= tail_w.py;
   end

   // Output register: blank every field of a load or clipped beat
   logic               rsp_strobe_ff;
   logic               rsp_visible_ff;
   logic [COORD_W-1:0] rsp_x_ff;
   logic [COORD_W-1:0] rsp_y_ff;
   logic [TEXEL_W-1:0] rsp_texel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_visible_ff <= rd_vis_ff;
      rsp_x_ff       <= rd_vis_ff ? rd_px_ff : '0;
      rsp_y_ff       <= rd_vis_ff ? rd_py_ff : '0;
      rsp_texel_ff   <= rd_vis_ff ? ram_rdata : '0;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_visible   = rsp_strobe_ff && rsp_visible_ff;
   assign rsp_screen_x  = rsp_x_ff;
   assign rsp_screen_y  = rsp_y_ff;
   assign rsp_red_out   = rsp_texel_ff[TEXEL_W-1 -: COLOR_W];
   assign rsp_green_out = rsp_texel_ff[COLOR_W +: COLOR_W];
   assign rsp_blue_out  = rsp_texel_ff[COLOR_W-1:0];

`ifndef SYNTHESIS
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result beat right after reset");

   a_load_blank: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ##2 (rsp_strobe && !rsp_visible))
      else $error("load did not return a blank result beat");

   a_blank_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_visible) |-> (rsp_screen_x == '0 && rsp_screen_y == '0 &&
         rsp_red_out == '0 && rsp_green_out == '0 && rsp_blue_out == '0))
      else $error("hidden result beat carries data");

   a_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_visible |-> ({1'b0, rsp_screen_x} < (COORD_W+1)'(SCREEN_WIDTH) &&
                       {1'b0, rsp_screen_y} < (COORD_W+1)'(SCREEN_HEIGHT)))
      else $error("visible pixel off screen");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[QW] && tail_w.vis) |-> ({1'b0, ram_addr} < (AW+1)'(DEPTH)))
      else $error("sample address beyond texel store");
`endif

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb
   import nnss_pkg::*;
();

   localparam int SRC     = SRC_SIZE_DEF;
   localparam int SCR_W   = SCREEN_WIDTH_DEF;
   localparam int SCR_H   = SCREEN_HEIGHT_DEF;
   localparam int LATENCY = $clog2(SRC) + 3;
   localparam int LIMIT   = 200000;
   localparam int N_ITEMS = 1925;

   typedef enum logic [1:0] {
      STEP_ITEM,
      STEP_CSR,
      STEP_DRAIN
   } step_kind_type;

   typedef struct packed {
      step_kind_type         kind;
      logic                  cmd;
      logic [COORD_W-1:0]    col;
      logic [COORD_W-1:0]    row;
      logic [COLOR_W-1:0]    red;
      logic [COLOR_W-1:0]    green;
      logic [COLOR_W-1:0]    blue;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
   } step_type;

   typedef struct packed {
      logic               visible;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_cmd = CMD_LOAD;
   logic [COORD_W-1:0]    req_col = '0;
   logic [COORD_W-1:0]    req_row = '0;
   logic [COLOR_W-1:0]    req_red_in = '0;
   logic [COLOR_W-1:0]    req_green_in = '0;
   logic [COLOR_W-1:0]    req_blue_in = '0;
   logic                  rsp_strobe;
   logic                  rsp_visible;
   logic [COORD_W-1:0]    rsp_screen_x;
   logic [COORD_W-1:0]    rsp_screen_y;
   logic [COLOR_W-1:0]    rsp_red_out;
   logic [COLOR_W-1:0]    rsp_green_out;
   logic [COLOR_W-1:0]    rsp_blue_out;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_DEST_SIZE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   nearest_neighbor_sprite_scaler #(
      .SRC_SIZE      (SRC),
      .SCREEN_WIDTH  (SCR_W),
      .SCREEN_HEIGHT (SCR_H)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_strobe    (rsp_strobe),
      .rsp_visible   (rsp_visible),
      .rsp_screen_x  (rsp_screen_x),
      .rsp_screen_y  (rsp_screen_y),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Pending work for the driver, and the pixels the scaler still owes us
   step_type  step_q[$];
   pixel_type pixels_due[$];
   step_type  cur_beat = '0;

   int beats_sent = 0;
   int beats_seen = 0;
   int total_beats = 0;
   int on_screen = 0;
   int num_loads = 0;
   int num_samples = 0;
   int num_settings = 1;
   int num_drains = 0;
   int errors = 0;
   int cycles = 0;

   // Stimulus-side view of the registers and of which texels hold data
   int plan_dest = DEST_SIZE_RST;
   int plan_ox = 0;
   int plan_oy = 0;
   bit plan_loaded[SRC*SRC];

   // Predictor state: register copies and a mirror of the texel store
   logic [COORD_W-1:0]       pred_dest = DEST_SIZE_RST;
   logic signed [ORG_W-1:0]  pred_ox = '0;
   logic signed [ORG_W-1:0]  pred_oy = '0;
   logic [TEXEL_W-1:0]       texel_mirror[SRC*SRC];

   task automatic add_load(int col, int row, logic [TEXEL_W-1:0] rgb);
      step_type s;
      s = '0;
      s.kind = STEP_ITEM;
      s.cmd = CMD_LOAD;
      s.col = 8'(col);
      s.row = 8'(row);
      {s.red, s.green, s.blue} = rgb;
      if (col < SRC && row < SRC)
         plan_loaded[row*SRC + col] = 1'b1;
      step_q.push_back(s);
      total_beats++;
   endtask

   // Load the texel a sample maps to first, so no sample inside the destination reads an unwritten entry
   task automatic add_sample(int col, int row);
      step_type s;
      int       sx;
      int       sy;
      if (plan_dest != 0 && col < plan_dest && row < plan_dest) begin
         sx = col * SRC / plan_dest;
         sy = row * SRC / plan_dest;
         if (!plan_loaded[sy*SRC + sx])
            add_load(sx, sy, TEXEL_W'($urandom));
      end
      s = '0;
      s.kind = STEP_ITEM;
      s.cmd = CMD_SAMPLE;
      s.col = 8'(col);
      s.row = 8'(row);
      {s.red, s.green, s.blue} = TEXEL_W'($urandom);
      step_q.push_back(s);
      total_beats++;
   endtask

   task automatic add_csr(logic [CSR_IDX_W-1:0] idx, int val);
      step_type s;
      s = '0;
      s.kind = STEP_CSR;
      s.csr_idx = idx;
      s.csr_val = CSR_DATA_W'(val);
      case (idx)
         CSR_DEST_SIZE: plan_dest = val & 8'hFF;
         CSR_ORIGIN_X:  plan_ox = val;
         CSR_ORIGIN_Y:  plan_oy = val;
         default: ;
      endcase
      step_q.push_back(s);
   endtask

   task automatic add_drain();
      step_type s;
      s = '0;
      s.kind = STEP_DRAIN;
      step_q.push_back(s);
      num_drains++;
   endtask

   // Favor coordinates that land on screen, with some in range and some wild
   function automatic int pick_coord(int org, int screen);
      int lo;
      int hi;
      int r;
      r = $urandom_range(99);
      lo = (org < 0) ? -org : 0;
      hi = plan_dest - 1;
      if (screen - 1 - org < hi)
         hi = screen - 1 - org;
      if (r < 65 && lo <= hi)
         return $urandom_range(hi, lo);
      else if (r < 85 && plan_dest > 0)
         return $urandom_range(plan_dest - 1, 0);
      return $urandom_range(255, 0);
   endfunction

   // Scale, clip and fetch: the pixel one accepted beat must produce
   task automatic scale_pixel(input step_type s);
      pixel_type p;
      int        px;
      int        py;
      int        sx;
      int        sy;
      p = '0;
      if (s.cmd == CMD_LOAD) begin
         num_loads++;
         if (s.col < SRC && s.row < SRC)
            texel_mirror[int'(s.row)*SRC + int'(s.col)] = {s.red, s.green, s.blue};
      end else begin
         num_samples++;
         if (pred_dest != 0 && s.col < pred_dest && s.row < pred_dest) begin
            px = int'(pred_ox) + int'(s.col);
            py = int'(pred_oy) + int'(s.row);
            if (px >= 0 && px < SCR_W && py >= 0 && py < SCR_H) begin
               sx = int'(s.col) * SRC / int'(pred_dest);
               sy = int'(s.row) * SRC / int'(pred_dest);
               p.visible = 1'b1;
               p.x = px[COORD_W-1:0];
               p.y = py[COORD_W-1:0];
               {p.red, p.green, p.blue} = texel_mirror[sy*SRC + sx];
            end
         end
      end
      pixels_due.push_back(p);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
         errors++;
      end
   endtask

   // Driver: predict on acceptance, then pick the next beat, register write or drain
   always @(posedge clock) begin
      step_type nxt;
      logic     go;
      logic     wr;
      logic     idle;
      int       sent;
      int       idle_pct;
      go = 1'b0;
      wr = 1'b0;
      nxt = cur_beat;
      sent = beats_sent;
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
      end else begin
         if (start && !busy) begin
            scale_pixel(cur_beat);
            sent++;
         end
         idle = (sent == beats_seen);
         if (sent * 3 < total_beats)
            idle_pct = 25;
         else if (sent * 3 < total_beats * 2)
            idle_pct = 53;
         else
            idle_pct = 0;

         if (start && busy) begin
            // hold the beat until it is taken
            go = 1'b1;
         end else if (step_q.size() != 0) begin
            case (step_q[0].kind)
               STEP_CSR: if (idle) begin
                  wr = 1'b1;
                  case (step_q[0].csr_idx)
                     CSR_DEST_SIZE: pred_dest = step_q[0].csr_val[COORD_W-1:0];
                     CSR_ORIGIN_X:  pred_ox = step_q[0].csr_val;
                     CSR_ORIGIN_Y:  pred_oy = step_q[0].csr_val;
                     default: ;
                  endcase
                  csr_index <= step_q[0].csr_idx;
                  csr_wdata <= step_q[0].csr_val;
                  void'(step_q.pop_front());
               end
               STEP_DRAIN: if (idle) begin
                  void'(step_q.pop_front());
               end
               default: if ($urandom_range(99) >= idle_pct) begin
                  go = 1'b1;
                  nxt = step_q.pop_front();
               end
            endcase
         end
         start <= go;
         csr_we <= wr;
      end
      cur_beat <= nxt;
      beats_sent <= sent;
      req_cmd <= nxt.cmd;
      req_col <= nxt.col;
      req_row <= nxt.row;
      req_red_in <= nxt.red;
      req_green_in <= nxt.green;
      req_blue_in <= nxt.blue;
   end

   // Monitor: compare each result beat against the oldest expected pixel
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_strobe) begin
         beats_seen <= beats_seen + 1;
         if (pixels_due.size() == 0) begin
            $display("%0t: result with nothing expected, expected none actual %0h",
                     $realtime, {rsp_visible, rsp_screen_x, rsp_screen_y,
                                 rsp_red_out, rsp_green_out, rsp_blue_out});
            errors++;
         end else begin
            want = pixels_due.pop_front();
            if (want.visible)
               on_screen++;
            check_field("visible", want.visible, rsp_visible);
            check_field("screen_x", want.x, rsp_screen_x);
            check_field("screen_y", want.y, rsp_screen_y);
            check_field("red_out", want.red, rsp_red_out);
            check_field("green_out", want.green, rsp_green_out);
            check_field("blue_out", want.blue, rsp_blue_out);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("%0t: timed out with %0d of %0d results", $realtime, beats_seen, total_beats);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int n_items;
      int drain_at;
      int dest;
      int ox;
      int oy;
      int ph;
      foreach (texel_mirror[i])
         texel_mirror[i] = '0;

      // Directed: corners, color extremes, dropped loads and clipping at reset settings
      add_load(0, 0, 24'h000000);
      add_load(SRC - 1, 0, 24'hFFFFFF);
      add_load(0, SRC - 1, 24'hA55AC3);
      add_load(SRC - 1, SRC - 1, 24'h5AA53C);
      add_load(SRC, 0, 24'h123456);
      add_load(0, SRC, 24'h654321);
      add_load(255, 255, 24'hFFFFFF);
      add_sample(0, 0);
      add_sample(SRC - 1, 0);
      add_sample(0, SCR_H - 1);
      add_sample(SRC - 1, SRC - 1);
      add_sample(DEST_SIZE_RST, 0);
      add_sample(0, DEST_SIZE_RST);
      add_sample(255, 255);
      add_sample(255, 0);
      add_load(0, 0, 24'hFFFFFF);
      add_sample(0, 0);
      add_drain();
      // zero size hides everything
      add_csr(CSR_DEST_SIZE, 0);
      num_settings++;
      add_sample(0, 0);
      add_sample(255, 255);
      add_sample(1, 1);

      // Random phases, each under its own register setting
      ph = 0;
      while (total_beats < N_ITEMS) begin
         case (ph)
            0: begin dest = 1;   ox = 0;    oy = 0;    end
            1: begin dest = 255; ox = -200; oy = -230; end
            2: begin dest = 0;   ox = -256; oy = 255;  end
            3: begin dest = 40;  ox = 255;  oy = -256; end
            4: begin dest = 80;  ox = -10;  oy = -5;   end
            default: begin
               dest = $urandom_range(1) ? $urandom_range(64, 1) : $urandom_range(255, 1);
               ox = int'($urandom_range(103)) - 40;
               oy = int'($urandom_range(71)) - 40;
            end
         endcase
         add_csr(CSR_DEST_SIZE, dest);
         add_csr(CSR_ORIGIN_X, ox);
         add_csr(CSR_ORIGIN_Y, oy);
         num_settings++;
         n_items = (ph == 2 || ph == 3) ? 60 : $urandom_range(220, 120);
         // trim the last phase so the run stays near its item budget
         if (n_items > N_ITEMS - total_beats)
            n_items = N_ITEMS - total_beats;
         drain_at = $urandom_range(n_items - 1);
         for (int i = 0; i < n_items; i++) begin
            if (i == drain_at)
               add_drain();
            if ($urandom_range(99) < 25) begin
               if ($urandom_range(99) < 85)
                  add_load($urandom_range(SRC - 1), $urandom_range(SRC - 1),
                           TEXEL_W'($urandom));
               else
                  add_load($urandom_range(255), $urandom_range(255), TEXEL_W'($urandom));
            end else begin
               add_sample(pick_coord(plan_ox, SCR_W), pick_coord(plan_oy, SCR_H));
            end
         end
         ph++;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait out every result, then keep watching for stray beats
      while (beats_seen < total_beats)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);

      while (pixels_due.size() != 0) begin
         $display("%0t: pixel never returned, expected %0h actual none",
                  $realtime, pixels_due.pop_front());
         errors++;
      end

      $display("Covered %0d texel loads and %0d samples, %0d of them on screen,",
               num_loads, num_samples, on_screen);
      $display("under %0d register settings with %0d forced drains and varied sender gaps.",
               num_settings, num_drains);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
